// File: design/mte_pkg.sv
// ----------------------------------------------------------------------------
// mte_pkg
// Types and constants shared by the timer expiry unit: action and status
// codes, the controller states and the per-timer record carried by the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package mte_pkg;

    localparam int TIMERS_DEF = 16;
    localparam int TICK_W     = 32;
    localparam int TIME_W     = TICK_W + 1;
    localparam int ID_W       = 4;

    typedef enum logic [2:0] {
        ACT_TICK        = 3'd0,
        ACT_SET         = 3'd1,
        ACT_CANCEL      = 3'd2,
        ACT_CANCEL_NEXT = 3'd3,
        ACT_CANCEL_ALL  = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NOT_ARMED     = 2'd1,
        ST_ZERO_INTERVAL = 2'd2
    } t_status;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    // One timer: deadline is the 33-bit time (epoch bit on top).
    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [TICK_W-1:0] period;
        logic              one_shot;
        logic              armed;
    } t_entry;

endpackage

`default_nettype wire

// File: design/multi_timer_expiry_unit_top.sv
// ----------------------------------------------------------------------------
// multi_timer_expiry_unit_top
// Bank of one-shot and periodic timers on a shared 33-bit tick time. Timer
// records circulate through a ring of cells past a single update point.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload
//  input     i_in_valid / o_in_stall    i_action, i_slot, i_interval,
//                                       i_single_use
//  output    o_out_valid / i_out_stall  o_kind, o_fired_id, o_status, o_last
//
// A transaction is accepted, then the ring rotates once so that every timer
// passes the head, and a flush step sends the final result. The input stalls
// until the flush is done. A stalled output holds the ring whenever a second
// due timer is found while a result is still waiting.
// Reset is synchronous and leaves every timer disarmed at time zero.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_timer_expiry_unit_top #(
    parameter int TIMERS = mte_pkg::TIMERS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [2:0]                  i_action,
    input  wire logic [mte_pkg::ID_W-1:0]    i_slot,
    input  wire logic [mte_pkg::TICK_W-1:0]  i_interval,
    input  wire logic                        i_single_use,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_kind,
    output logic [mte_pkg::ID_W-1:0]         o_fired_id,
    output logic [1:0]                       o_status,
    output logic                             o_last
);

    mte_pkg::t_entry w_cell [TIMERS];
    mte_pkg::t_entry w_tail;
    logic            w_shift;

    mte_ctrl #(
        .TIMERS (TIMERS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_slot       (i_slot),
        .i_interval   (i_interval),
        .i_single_use (i_single_use),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_fired_id   (o_fired_id),
        .o_status     (o_status),
        .o_last       (o_last),
        .i_head       (w_cell[0]),
        .o_tail       (w_tail),
        .o_shift      (w_shift)
    );

    // Records move toward cell 0; the updated head re-enters at the far end,
    // so after a full rotation every timer is back in its own cell.
    for (genvar k = 0; k < TIMERS; k++) begin : g_ring
        if (k == TIMERS - 1) begin : g_end
            mte_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_entry (w_tail),
                .o_entry (w_cell[k])
            );
        end else begin : g_mid
            mte_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_entry (w_cell[k+1]),
                .o_entry (w_cell[k])
            );
        end
    end

endmodule

`default_nettype wire

// File: design/mte_cell.sv
// ----------------------------------------------------------------------------
// mte_cell
// One link of the timer ring. Holds one timer record and passes it to its
// neighbor on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module mte_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire mte_pkg::t_entry i_entry,
    output mte_pkg::t_entry      o_entry
);

    mte_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.armed    <= 1'b0;
            r_entry.one_shot <= 1'b1;
            r_entry.deadline <= '0;
            r_entry.period   <= '0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// File: design/mte_ctrl.sv
// ----------------------------------------------------------------------------
// mte_ctrl
// Sequencer at the head of the timer ring: holds the current time, applies
// the command to each record as it passes the head, and orders the results.
// ----------------------------------------------------------------------------
`default_nettype none

module mte_ctrl #(
    parameter int TIMERS = mte_pkg::TIMERS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [2:0]                  i_action,
    input  wire logic [mte_pkg::ID_W-1:0]    i_slot,
    input  wire logic [mte_pkg::TICK_W-1:0]  i_interval,
    input  wire logic                        i_single_use,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_kind,
    output logic [mte_pkg::ID_W-1:0]         o_fired_id,
    output logic [1:0]                       o_status,
    output logic                             o_last,
    input  wire mte_pkg::t_entry             i_head,
    output mte_pkg::t_entry                  o_tail,
    output logic                             o_shift
);

    localparam int CW = $clog2(TIMERS + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(TIMERS - 1);

    mte_pkg::t_state                r_state, n_state;
    logic [CW-1:0]                  r_cnt, n_cnt;
    logic [mte_pkg::TIME_W-1:0]     r_now, n_now;

    mte_pkg::t_action               r_act;
    logic [mte_pkg::ID_W-1:0]       r_id;
    logic [mte_pkg::TICK_W-1:0]     r_interval;
    logic                           r_single;

    logic                           r_pend_valid, n_pend_valid;
    logic                           r_pend_kind, n_pend_kind;
    logic [mte_pkg::ID_W-1:0]       r_pend_id, n_pend_id;
    mte_pkg::t_status               r_pend_status, n_pend_status;

    logic                           r_out_valid;
    logic                           r_out_kind;
    logic [mte_pkg::ID_W-1:0]       r_out_id;
    logic [1:0]                     r_out_status;
    logic                           r_out_last;

    logic                           w_accept;
    logic                           w_act_ok;
    logic                           w_out_free;
    logic                           w_hit;
    logic                           w_here;
    logic                           w_emit;
    logic                           w_emit_last;
    logic [mte_pkg::TICK_W-1:0]     w_addend;
    logic [mte_pkg::TIME_W-1:0]     w_sum;
    mte_pkg::t_entry                w_upd;

    // Ticks and cancel-all never address a timer; other actions must name
    // an existing one. Codes above cancel-all are dropped.
    always_comb begin
        case (i_action)
            mte_pkg::ACT_TICK,
            mte_pkg::ACT_CANCEL_ALL: w_act_ok = 1'b1;
            mte_pkg::ACT_SET,
            mte_pkg::ACT_CANCEL,
            mte_pkg::ACT_CANCEL_NEXT: w_act_ok = 32'(i_slot) < 32'(TIMERS);
            default: w_act_ok = 1'b0;
        endcase
    end

    assign o_in_stall = (r_state != mte_pkg::S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_hit  = (r_act == mte_pkg::ACT_TICK) && i_head.armed && (i_head.deadline == r_now);
    assign w_here = (r_act == mte_pkg::ACT_CANCEL_ALL) ? (r_cnt == '0)
                                                        : (32'(r_cnt) == 32'(r_id));
    assign w_addend = (r_act == mte_pkg::ACT_TICK) ? i_head.period : r_interval;
    assign w_sum    = r_now + mte_pkg::TIME_W'(w_addend);

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_now         = r_now;
        n_pend_valid  = r_pend_valid;
        n_pend_kind   = r_pend_kind;
        n_pend_id     = r_pend_id;
        n_pend_status = r_pend_status;
        w_emit        = 1'b0;
        w_emit_last   = 1'b0;
        o_shift       = 1'b0;
        w_upd         = i_head;

        unique case (r_state)
            mte_pkg::S_IDLE: begin
                if (w_accept && w_act_ok) begin
                    n_state = mte_pkg::S_SCAN;
                    n_cnt   = '0;
                end
            end

            mte_pkg::S_SCAN: begin
                // A second due timer must push the held one out first, so the
                // ring waits while the output register is still occupied.
                if (!(w_hit && r_pend_valid && !w_out_free)) begin
                    o_shift = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    if (r_cnt == LAST_IDX) begin
                        n_state = mte_pkg::S_FLUSH;
                    end
                    if (w_hit) begin
                        w_emit        = r_pend_valid;
                        n_pend_valid  = 1'b1;
                        n_pend_kind   = mte_pkg::KIND_EXPIRY;
                        n_pend_id     = mte_pkg::ID_W'(r_cnt);
                        n_pend_status = mte_pkg::ST_OK;
                        if (i_head.one_shot) begin
                            w_upd.armed = 1'b0;
                        end else begin
                            w_upd.deadline = w_sum;
                        end
                    end
                    if (r_act == mte_pkg::ACT_CANCEL_ALL) begin
                        w_upd.armed = 1'b0;
                    end
                    if (w_here && (r_act != mte_pkg::ACT_TICK)) begin
                        n_pend_valid  = 1'b1;
                        n_pend_kind   = mte_pkg::KIND_STATUS;
                        n_pend_id     = (r_act == mte_pkg::ACT_CANCEL_ALL) ? '0 : r_id;
                        n_pend_status = mte_pkg::ST_OK;
                        case (r_act)
                            mte_pkg::ACT_SET: begin
                                if (r_interval == '0) begin
                                    n_pend_status = mte_pkg::ST_ZERO_INTERVAL;
                                end else begin
                                    w_upd.period   = r_interval;
                                    w_upd.one_shot = r_single;
                                    w_upd.deadline = w_sum;
                                    w_upd.armed    = 1'b1;
                                end
                            end
                            mte_pkg::ACT_CANCEL: begin
                                if (!i_head.armed) begin
                                    n_pend_status = mte_pkg::ST_NOT_ARMED;
                                end
                                w_upd.armed = 1'b0;
                            end
                            mte_pkg::ACT_CANCEL_NEXT: begin
                                w_upd.one_shot = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end

            mte_pkg::S_FLUSH: begin
                if (!r_pend_valid || w_out_free) begin
                    w_emit       = r_pend_valid;
                    w_emit_last  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = mte_pkg::S_IDLE;
                    // The epoch bit toggles on its own when the low word wraps.
                    if (r_act == mte_pkg::ACT_TICK) begin
                        n_now = r_now + 1'b1;
                    end else if (r_act == mte_pkg::ACT_CANCEL_ALL) begin
                        n_now = '0;
                    end
                end
            end

            default: begin
                n_state = mte_pkg::S_IDLE;
            end
        endcase
    end

    assign o_tail = w_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mte_pkg::S_IDLE;
            r_cnt        <= '0;
            r_now        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_now        <= n_now;
            r_pend_valid <= n_pend_valid;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act      <= mte_pkg::t_action'(i_action);
            r_id       <= i_slot;
            r_interval <= i_interval;
            r_single   <= i_single_use;
        end
        r_pend_kind   <= n_pend_kind;
        r_pend_id     <= n_pend_id;
        r_pend_status <= n_pend_status;
        if (w_emit) begin
            r_out_kind   <= r_pend_kind;
            r_out_id     <= r_pend_id;
            r_out_status <= r_pend_status;
            r_out_last   <= w_emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_fired_id  = r_out_id;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

// File: bench/tb_multi_timer_expiry_unit_top.sv
// ----------------------------------------------------------------------------
// tb_multi_timer_expiry_unit_top
// Self-checking bench for the timer expiry unit. A short directed sequence
// covers every action and the corner cases of arming and cancelling. Four
// random phases then follow, each opening with a burst that arms the whole
// bank so that many timers fall due on the same tick. The phases vary the
// idle gaps on the sender and the output stalls. A scoreboard keeps its own
// copy of the timer bank and checks each reply against its prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multi_timer_expiry_unit_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TIMERS    = mte_pkg::TIMERS_DEF;
    localparam int ID_W          = mte_pkg::ID_W;
    localparam int TICK_W        = mte_pkg::TICK_W;
    localparam int TIME_W        = mte_pkg::TIME_W;
    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RUN_LIMIT_NS  = 4_000_000;
    localparam int PHASE_ITEMS   = 70;
    localparam int BURST_TICKS   = 6;

    // Action codes that the block does not define and must ignore.
    localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   fired_id;
        logic [1:0]        status;
        logic              last;
    } t_reply;

    // Mirror of the timer bank plus the queue of replies still to come.
    class t_scoreboard;
        logic [TIME_W-1:0] now_time;
        logic [TIME_W-1:0] deadline [NUM_TIMERS];
        logic [TICK_W-1:0] period   [NUM_TIMERS];
        bit                one_shot [NUM_TIMERS];
        bit                armed    [NUM_TIMERS];
        t_reply            expected_replies [$];
        int                mismatches;

        function new();
            now_time   = '0;
            mismatches = 0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                deadline[i] = '0;
                period[i]   = '0;
                one_shot[i] = 1'b1;
                armed[i]    = 1'b0;
            end
        endfunction

        function void push_reply(logic kind, int id, logic [1:0] st, logic last);
            t_reply r;
            r.kind     = kind;
            r.fired_id = ID_W'(id);
            r.status   = st;
            r.last     = last;
            expected_replies.push_back(r);
        endfunction

        function void note_input(logic [2:0] act, logic [ID_W-1:0] id,
                                 logic [TICK_W-1:0] intv, logic single);
            int due [$];
            case (act)
                mte_pkg::ACT_TICK: begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (armed[i] && deadline[i] == now_time) begin
                            due.push_back(i);
                            if (one_shot[i])
                                armed[i] = 1'b0;
                            else
                                deadline[i] = now_time + {1'b0, period[i]};
                        end
                    end
                    foreach (due[k])
                        push_reply(mte_pkg::KIND_EXPIRY, due[k], mte_pkg::ST_OK,
                                   k == due.size() - 1);
                    // The carry out of the tick count toggles the epoch bit.
                    now_time = now_time + 1'b1;
                end
                mte_pkg::ACT_SET: begin
                    if (intv == '0) begin
                        push_reply(mte_pkg::KIND_STATUS, id, mte_pkg::ST_ZERO_INTERVAL,
                                   1'b1);
                    end else begin
                        period[id]   = intv;
                        one_shot[id] = single;
                        deadline[id] = now_time + {1'b0, intv};
                        armed[id]    = 1'b1;
                        push_reply(mte_pkg::KIND_STATUS, id, mte_pkg::ST_OK, 1'b1);
                    end
                end
                mte_pkg::ACT_CANCEL: begin
                    if (!armed[id]) begin
                        push_reply(mte_pkg::KIND_STATUS, id, mte_pkg::ST_NOT_ARMED, 1'b1);
                    end else begin
                        armed[id] = 1'b0;
                        push_reply(mte_pkg::KIND_STATUS, id, mte_pkg::ST_OK, 1'b1);
                    end
                end
                mte_pkg::ACT_CANCEL_NEXT: begin
                    one_shot[id] = 1'b1;
                    push_reply(mte_pkg::KIND_STATUS, id, mte_pkg::ST_OK, 1'b1);
                end
                mte_pkg::ACT_CANCEL_ALL: begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                        armed[i] = 1'b0;
                    now_time = '0;
                    push_reply(mte_pkg::KIND_STATUS, 0, mte_pkg::ST_OK, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_reply(t_reply got);
            t_reply want;
            if (expected_replies.size() == 0) begin
                mismatches++;
                $display("%0t: reply with none pending: actual kind=%0d id=%0d %s",
                         $realtime, got.kind, got.fired_id,
                         $sformatf("status=%0d last=%0d", got.status, got.last));
                return;
            end
            want = expected_replies.pop_front();
            if (got !== want) begin
                mismatches++;
                $display("%0t: reply mismatch: expected kind=%0d id=%0d %s, %s",
                         $realtime, want.kind, want.fired_id,
                         $sformatf("status=%0d last=%0d", want.status, want.last),
                         $sformatf("actual kind=%0d id=%0d status=%0d last=%0d",
                                   got.kind, got.fired_id, got.status, got.last));
            end
        endfunction

        function int outstanding();
            return expected_replies.size();
        endfunction
    endclass

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [2:0]        action     = mte_pkg::ACT_TICK;
    logic [ID_W-1:0]   slot       = '0;
    logic [TICK_W-1:0] interval   = '0;
    logic              single_use = 1'b0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic              kind;
    logic [ID_W-1:0]   fired_id;
    logic [1:0]        status;
    logic              last;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int idle_by_phase  [4] = '{0, 80, 0, 12};
    int stall_by_phase [4] = '{0, 0, 80, 12};

    t_scoreboard replies = new();

    multi_timer_expiry_unit_top u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_action     (action),
        .i_slot       (slot),
        .i_interval   (interval),
        .i_single_use (single_use),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_kind       (kind),
        .o_fired_id   (fired_id),
        .o_status     (status),
        .o_last       (last)
    );

    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            replies.check_reply({kind, fired_id, status, last});
    end

    // Called right after a falling edge; returns right after the falling edge
    // that follows acceptance, with valid still high.
    task automatic send_item(logic [2:0] act, logic [ID_W-1:0] id,
                             logic [TICK_W-1:0] intv, logic single);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        slot       <= id;
        interval   <= intv;
        single_use <= single;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        replies.note_input(act, id, intv, single);
        @(negedge clk);
    endtask

    // The unused fields of a tick carry random values.
    task automatic send_tick();
        send_item(mte_pkg::ACT_TICK, ID_W'($urandom_range(0, NUM_TIMERS - 1)), $urandom(),
                  1'($urandom_range(0, 1)));
    endtask

    // Arms the whole bank with one short interval so that every timer falls
    // due on the same tick, then ticks past that point.
    task automatic arm_whole_bank();
        logic [TICK_W-1:0] intv;
        intv = $urandom_range(1, 4);
        for (int i = 0; i < NUM_TIMERS; i++)
            send_item(mte_pkg::ACT_SET, ID_W'(i), intv, 1'($urandom_range(0, 1)));
        repeat (BURST_TICKS)
            send_tick();
    endtask

    task automatic send_random_item(output bit defined);
        int                pick;
        int                span;
        logic [2:0]        act;
        logic [TICK_W-1:0] intv;
        pick = $urandom_range(0, 99);
        span = $urandom_range(0, 9);
        if (span == 0)
            intv = '0;
        else if (span < 3)
            intv = $urandom();
        else
            intv = $urandom_range(1, 8);
        if (pick < 50)
            act = mte_pkg::ACT_TICK;
        else if (pick < 72)
            act = mte_pkg::ACT_SET;
        else if (pick < 82)
            act = mte_pkg::ACT_CANCEL;
        else if (pick < 92)
            act = mte_pkg::ACT_CANCEL_NEXT;
        else if (pick < 95)
            act = mte_pkg::ACT_CANCEL_ALL;
        else
            act = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
        defined = (act <= mte_pkg::ACT_CANCEL_ALL);
        send_item(act, ID_W'($urandom_range(0, NUM_TIMERS - 1)), intv,
                  1'($urandom_range(0, 1)));
    endtask

    initial begin
        int sent;
        bit defined;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: every action and the corner cases.
        send_tick();
        send_item(mte_pkg::ACT_CANCEL, 4'd3, 32'd0, 1'b0);
        send_item(mte_pkg::ACT_CANCEL_NEXT, 4'd3, 32'd0, 1'b0);
        send_item(mte_pkg::ACT_SET, 4'd0, 32'd0, 1'b1);
        send_item(mte_pkg::ACT_SET, 4'd15, 32'hFFFF_FFFF, 1'b1);
        send_item(mte_pkg::ACT_SET, 4'd0, 32'd1, 1'b1);
        send_item(mte_pkg::ACT_SET, 4'd5, 32'd1, 1'b0);
        send_item(mte_pkg::ACT_SET, 4'd9, 32'd2, 1'b0);
        repeat (4) send_tick();
        send_item(mte_pkg::ACT_CANCEL_NEXT, 4'd5, 32'd0, 1'b0);
        repeat (2) send_tick();
        send_item(mte_pkg::ACT_CANCEL, 4'd9, 32'd0, 1'b0);
        send_item(mte_pkg::ACT_SET, 4'd7, 32'd3, 1'b0);
        send_item(mte_pkg::ACT_SET, 4'd7, 32'd1, 1'b1);
        send_item(ACT_UNUSED_FIRST, 4'd2, 32'd1, 1'b0);
        send_item(3'd6, 4'd2, 32'd1, 1'b0);
        send_item(ACT_UNUSED_LAST, 4'd2, 32'd1, 1'b0);
        repeat (2) send_tick();
        send_item(mte_pkg::ACT_CANCEL_ALL, 4'd11, 32'd5, 1'b1);
        send_tick();

        // Random phases with different idle and stall patterns.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_by_phase[phase];
            recv_stall_pct = stall_by_phase[phase];
            arm_whole_bank();
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                send_random_item(defined);
                if (defined)
                    sent++;
            end
        end

        in_valid       <= 1'b0;
        recv_stall_pct = 0;
        while (replies.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (replies.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
design/mte_pkg.sv
design/mte_cell.sv
design/mte_ctrl.sv
design/multi_timer_expiry_unit_top.sv
bench/tb_multi_timer_expiry_unit_top.sv
